// ----- rtl/hse_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hse_pkg
// shared widths, codes, state type and key mask helper of the hash set engine
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int KEY_W           = 64;
  localparam int ACT_W           = 2;
  localparam int KB_W            = 4;
  localparam int LOW_W           = 32;
  localparam int NUM_BUCKETS_DEF = 64;
  localparam int WAYS_DEF        = 4;

  localparam logic [KB_W-1:0] KB_RESET = 4'd4;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD      = 2'd0,
    ACT_CONTAINS = 2'd1,
    ACT_REMOVE   = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_VREAD,
    ST_CMP,
    ST_WRITE,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic clearing;
    logic writing;
  } hse_status_t;

  // byte mask over the low key_bytes bytes, zero acts as one, above eight as eight
  function automatic logic [KEY_W-1:0] key_mask(input logic [KB_W-1:0] kb);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int i = 0; i < KEY_W / 8; i++) begin
      if (i == 0 || kb > KB_W'(i)) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/hse_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hse_if
// valid/ready channels of the hash set engine: request, response, config
// ----------------------------------------------------------------------------
interface hse_req_if;
  import hse_pkg::*;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [KEY_W-1:0] key;
  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

interface hse_rsp_if;
  logic valid;
  logic ready;
  logic success;
  logic bucket_full;
  modport source (output valid, output success, output bucket_full, input ready);
  modport sink   (input valid, input success, input bucket_full, output ready);
endinterface

interface hse_cfg_if;
  import hse_pkg::*;
  logic            valid;
  logic            ready;
  logic [KB_W-1:0] key_bytes;
  modport source (output valid, output key_bytes, input ready);
  modport sink   (input valid, input key_bytes, output ready);
endinterface
`default_nettype wire

// ----- rtl/hse_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hse_ram
// simple dual port memory, one write port, one registered read port
// ----------------------------------------------------------------------------
module hse_ram #(
  parameter  int DATA_W = hse_pkg::KEY_W,
  parameter  int DEPTH  = hse_pkg::NUM_BUCKETS_DEF,
  localparam int AW     = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/hse_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hse_seq
// request sequencer: bucket reduction, way by way compare, slot update
// ----------------------------------------------------------------------------
module hse_seq #(
  parameter  int NUM_BUCKETS = hse_pkg::NUM_BUCKETS_DEF,
  parameter  int WAYS        = hse_pkg::WAYS_DEF,
  localparam int BKT_W       = $clog2(NUM_BUCKETS),
  localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int SLOT_W      = $clog2(NUM_BUCKETS * WAYS)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  hse_req_if.sink                        req,
  hse_rsp_if.source                      rsp,
  hse_cfg_if.sink                        cfg,
  output logic                           vram_we_o,
  output logic      [BKT_W-1:0]          vram_waddr_o,
  output logic      [WAYS-1:0]           vram_wdata_o,
  output logic      [BKT_W-1:0]          vram_raddr_o,
  input  wire logic [WAYS-1:0]           vram_rdata_i,
  output logic                           kram_we_o,
  output logic      [SLOT_W-1:0]         kram_waddr_o,
  output logic      [hse_pkg::KEY_W-1:0] kram_wdata_o,
  output logic      [SLOT_W-1:0]         kram_raddr_o,
  input  wire logic [hse_pkg::KEY_W-1:0] kram_rdata_i,
  output hse_pkg::hse_status_t           status_o
);
  import hse_pkg::*;

  localparam int RW = BKT_W + 9;
  localparam int MOD_BYTES = LOW_W / 8;

  // one byte of the low word folded into the running remainder
  function automatic logic [BKT_W-1:0] mod_step(input logic [BKT_W-1:0] r,
                                                input logic [7:0] b);
    logic [RW-1:0] t;
    t = RW'({r, b});
    for (int k = 7; k >= 0; k--) begin
      if (t >= (RW'(NUM_BUCKETS) << k)) begin
        t = t - (RW'(NUM_BUCKETS) << k);
      end
    end
    return t[BKT_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_addr(input logic [BKT_W-1:0] b,
                                                  input logic [WAY_W-1:0] w);
    return SLOT_W'(int'(b) * WAYS + int'(w));
  endfunction

  state_e                 state_q, state_d;
  logic [KB_W-1:0]        kb_q, kb_d;
  logic [BKT_W-1:0]       clr_q, clr_d;
  logic [1:0]             cnt_q, cnt_d;
  logic [WAY_W-1:0]       way_q, way_d;
  logic                   hit_q, hit_d;
  logic                   free_q, free_d;
  logic                   rsp_valid_q, rsp_valid_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic [ACT_W-1:0]       act_q, act_d;
  logic [LOW_W-1:0]       lo_q, lo_d;
  logic [BKT_W-1:0]       rem_q, rem_d;
  logic [WAY_W-1:0]       hit_way_q, hit_way_d;
  logic [WAY_W-1:0]       free_way_q, free_way_d;
  logic                   res_succ_q, res_succ_d;
  logic                   res_full_q, res_full_d;
  logic                   rsp_succ_q, rsp_succ_d;
  logic                   rsp_full_q, rsp_full_d;
  logic [KEY_W-1:0]       mask;
  logic                   way_valid;
  logic                   key_eq;
  logic [WAYS-1:0]        row_upd;

  assign mask      = key_mask(kb_q);
  assign way_valid = vram_rdata_i[way_q];
  assign key_eq    = (kram_rdata_i & mask) == key_q;

  assign req.ready       = (state_q == ST_IDLE);
  assign cfg.ready       = 1'b1;
  assign rsp.valid       = rsp_valid_q;
  assign rsp.success     = rsp_succ_q;
  assign rsp.bucket_full = rsp_full_q;

  assign vram_raddr_o = rem_q;
  assign kram_raddr_o = slot_addr(rem_q, way_d);
  assign kram_waddr_o = slot_addr(rem_q, free_way_q);
  assign kram_wdata_o = key_q;

  assign status_o.clearing = (state_q == ST_CLEAR);
  assign status_o.writing  = (state_q == ST_WRITE);

  always_comb begin
    state_d      = state_q;
    kb_d         = kb_q;
    clr_d        = clr_q;
    cnt_d        = cnt_q;
    way_d        = way_q;
    hit_d        = hit_q;
    free_d       = free_q;
    key_d        = key_q;
    act_d        = act_q;
    lo_d         = lo_q;
    rem_d        = rem_q;
    hit_way_d    = hit_way_q;
    free_way_d   = free_way_q;
    res_succ_d   = res_succ_q;
    res_full_d   = res_full_q;
    rsp_succ_d   = rsp_succ_q;
    rsp_full_d   = rsp_full_q;
    rsp_valid_d  = rsp_valid_q && !rsp.ready;
    vram_we_o    = 1'b0;
    vram_waddr_o = rem_q;
    vram_wdata_o = '0;
    kram_we_o    = 1'b0;
    row_upd      = vram_rdata_i;

    if (cfg.valid) begin
      kb_d = cfg.key_bytes;
    end

    unique case (state_q)
      ST_CLEAR: begin
        vram_we_o    = 1'b1;
        vram_waddr_o = clr_q;
        clr_d        = clr_q + 1'b1;
        if (clr_q == BKT_W'(NUM_BUCKETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req.valid) begin
          key_d   = req.key & mask;
          act_d   = req.action;
          lo_d    = LOW_W'(req.key & mask);
          rem_d   = '0;
          cnt_d   = '0;
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        // msb byte first
        rem_d = mod_step(rem_q, lo_q[LOW_W-1 -: 8]);
        lo_d  = lo_q << 8;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 2'(MOD_BYTES - 1)) begin
          state_d = ST_VREAD;
        end
      end
      ST_VREAD: begin
        way_d   = '0;
        hit_d   = 1'b0;
        free_d  = 1'b0;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (way_valid) begin
          if (!hit_q && key_eq) begin
            hit_d     = 1'b1;
            hit_way_d = way_q;
          end
        end else if (!free_q) begin
          free_d     = 1'b1;
          free_way_d = way_q;
        end
        if (way_q == WAY_W'(WAYS - 1)) begin
          state_d = ST_WRITE;
        end else begin
          way_d = way_q + 1'b1;
        end
      end
      ST_WRITE: begin
        res_succ_d = 1'b0;
        res_full_d = 1'b0;
        case (act_q)
          ACT_ADD: begin
            if (!hit_q) begin
              if (free_q) begin
                row_upd[free_way_q] = 1'b1;
                vram_we_o  = 1'b1;
                kram_we_o  = 1'b1;
                res_succ_d = 1'b1;
              end else begin
                res_full_d = 1'b1;
              end
            end
          end
          ACT_CONTAINS: begin
            res_succ_d = hit_q;
          end
          ACT_REMOVE: begin
            if (hit_q) begin
              row_upd[hit_way_q] = 1'b0;
              vram_we_o  = 1'b1;
              res_succ_d = 1'b1;
            end
          end
          default: begin
          end
        endcase
        vram_wdata_o = row_upd;
        state_d      = ST_RESP;
      end
      ST_RESP: begin
        // hold until the output register is free
        if (!rsp_valid_q || rsp.ready) begin
          rsp_valid_d = 1'b1;
          rsp_succ_d  = res_succ_q;
          rsp_full_d  = res_full_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      kb_q        <= KB_RESET;
      clr_q       <= '0;
      cnt_q       <= '0;
      way_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kb_q        <= kb_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      way_q       <= way_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    act_q      <= act_d;
    lo_q       <= lo_d;
    rem_q      <= rem_d;
    hit_way_q  <= hit_way_d;
    free_way_q <= free_way_d;
    res_succ_q <= res_succ_d;
    res_full_q <= res_full_d;
    rsp_succ_q <= rsp_succ_d;
    rsp_full_q <= rsp_full_d;
  end

endmodule
`default_nettype wire

// ----- rtl/hash_set_engine_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hash_set_engine_unit
// set of keys in NUM_BUCKETS buckets of WAYS slots: add, contains, remove
// ----------------------------------------------------------------------------
// after accept: four byte steps of the bucket remainder, a valid row read, one
//   key memory read per way through the shared compare, the slot update and the
//   response register; a new request is taken only once the response is placed
// reset: async active low; a clearing pass over all NUM_BUCKETS buckets zeroes the
//   valid rows, no request is taken meanwhile, config writes are taken always
module hash_set_engine_unit #(
  parameter  int NUM_BUCKETS = hse_pkg::NUM_BUCKETS_DEF,
  parameter  int WAYS        = hse_pkg::WAYS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hse_req_if.sink   req_i,
  hse_rsp_if.source rsp_o,
  hse_cfg_if.sink   cfg_i
);
  import hse_pkg::*;

  localparam int BKT_W  = $clog2(NUM_BUCKETS);
  localparam int SLOT_W = $clog2(NUM_BUCKETS * WAYS);

  logic              vram_we;
  logic [BKT_W-1:0]  vram_waddr;
  logic [WAYS-1:0]   vram_wdata;
  logic [BKT_W-1:0]  vram_raddr;
  logic [WAYS-1:0]   vram_rdata;
  logic              kram_we;
  logic [SLOT_W-1:0] kram_waddr;
  logic [KEY_W-1:0]  kram_wdata;
  logic [SLOT_W-1:0] kram_raddr;
  logic [KEY_W-1:0]  kram_rdata;
  hse_status_t       status;

  hse_seq #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .WAYS        (WAYS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_i),
    .rsp          (rsp_o),
    .cfg          (cfg_i),
    .vram_we_o    (vram_we),
    .vram_waddr_o (vram_waddr),
    .vram_wdata_o (vram_wdata),
    .vram_raddr_o (vram_raddr),
    .vram_rdata_i (vram_rdata),
    .kram_we_o    (kram_we),
    .kram_waddr_o (kram_waddr),
    .kram_wdata_o (kram_wdata),
    .kram_raddr_o (kram_raddr),
    .kram_rdata_i (kram_rdata),
    .status_o     (status)
  );

  // one row of valid bits per bucket
  hse_ram #(
    .DATA_W (WAYS),
    .DEPTH  (NUM_BUCKETS)
  ) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vram_waddr),
    .wdata_i (vram_wdata),
    .raddr_i (vram_raddr),
    .rdata_o (vram_rdata)
  );

  hse_ram #(
    .DATA_W (KEY_W),
    .DEPTH  (NUM_BUCKETS * WAYS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (kram_we),
    .waddr_i (kram_waddr),
    .wdata_i (kram_wdata),
    .raddr_i (kram_raddr),
    .rdata_o (kram_rdata)
  );

  a_key_wr_with_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kram_we |-> (vram_we && status.writing))
    else $error("key write without valid row update");

  a_row_wr_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vram_we |-> (status.writing || status.clearing))
    else $error("valid row written outside update or clearing");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("ready right after an accepted item");

  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.clearing |-> !req_i.ready)
    else $error("request taken during clearing pass");

  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.success && rsp_o.bucket_full))
    else $error("success and bucket full both set");

endmodule
`default_nettype wire

// ----- tb/sv/tb_hash_set_engine_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hash_set_engine_unit
// Self-checking bench for the hash set engine. A directed table walks the
// empty set, duplicate adds, a full bucket, freeing a way, the unused action
// and masked upper key bytes. Then several key widths follow, each with random
// add/contains/remove/unused items, mostly from a small pool of keys that crowd
// a few buckets. A shadow copy of the buckets predicts the untyped responses.
// ----------------------------------------------------------------------------
module tb_hash_set_engine_unit;
  import hse_pkg::*;

  localparam int NUM_BUCKETS     = NUM_BUCKETS_DEF;
  localparam int WAYS            = WAYS_DEF;
  localparam int SLOTS           = NUM_BUCKETS * WAYS;
  localparam int LATENCY         = WAYS + 8;
  localparam int PHASES          = 8;
  localparam int PHASE_ITEMS     = 69;
  localparam int POOL_SIZE       = 16;
  localparam int HOT_BUCKETS     = 3;
  localparam int RSP_HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT     = 2000;
  localparam int MAX_REPORTS     = 40;
  localparam int DIR_ROWS        = 20;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic success;
    logic bucket_full;
  } reply_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [KEY_W-1:0] key;
    bit               typed;
    logic             success;
    logic             bucket_full;
  } dir_row_t;

  // typed rows carry their response, the rest take it from the shadow buckets
  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{ACT_CONTAINS, 64'h0000_0000_0000_0000, 1'b1, 1'b0, 1'b0},
    '{ACT_REMOVE,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0},
    '{ACT_ADD,      64'h0000_0000_0000_0000, 1'b1, 1'b1, 1'b0},
    '{ACT_ADD,      64'h0000_0000_0000_0000, 1'b1, 1'b0, 1'b0},
    '{ACT_CONTAINS, 64'hFFFF_FFFF_0000_0000, 1'b0, 1'b0, 1'b0},
    '{ACT_ADD,      64'h0000_0000_0000_0040, 1'b0, 1'b0, 1'b0},
    '{ACT_ADD,      64'h0000_0000_0000_0080, 1'b0, 1'b0, 1'b0},
    '{ACT_ADD,      64'h0000_0000_0000_00C0, 1'b0, 1'b0, 1'b0},
    '{ACT_ADD,      64'h0000_0000_0000_0100, 1'b1, 1'b0, 1'b1},
    '{ACT_REMOVE,   64'h0000_0000_0000_0040, 1'b0, 1'b0, 1'b0},
    '{ACT_ADD,      64'h0000_0000_0000_0100, 1'b0, 1'b0, 1'b0},
    '{ACT_CONTAINS, 64'h0000_0000_0000_0100, 1'b0, 1'b0, 1'b0},
    '{ACT_UNUSED,   64'h0000_0000_0000_0080, 1'b1, 1'b0, 1'b0},
    '{ACT_CONTAINS, 64'h0000_0000_0000_0080, 1'b0, 1'b0, 1'b0},
    '{ACT_ADD,      64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0},
    '{ACT_CONTAINS, 64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0, 1'b0},
    '{ACT_REMOVE,   64'hABCD_0000_FFFF_FFFF, 1'b0, 1'b0, 1'b0},
    '{ACT_CONTAINS, 64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0, 1'b0},
    '{ACT_REMOVE,   64'h0000_0000_FFFF_FFFF, 1'b1, 1'b0, 1'b0},
    '{ACT_UNUSED,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0}
  };

  // key widths per random phase, the last one is drawn at run time
  localparam logic [KB_W-1:0] KB_PLAN [PHASES] = '{
    4'd0, 4'd8, 4'd15, 4'd1, 4'd2, 4'd5, 4'd3, 4'd7
  };

  logic clk_i;
  logic rst_ni;

  hse_req_if req_if ();
  hse_rsp_if rsp_if ();
  hse_cfg_if cfg_if ();

  hash_set_engine_unit #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .WAYS        (WAYS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // shadow of the bucket store and the key width
  logic [KEY_W-1:0] shadow_key  [SLOTS];
  bit               shadow_used [SLOTS];
  logic [KB_W-1:0]  shadow_kb;

  reply_t pending_replies [$];
  int     error_count;
  int     quiet_cycles;
  bit     rsp_hold_req;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [KEY_W-1:0] width_mask(logic [KB_W-1:0] kb);
    int n;
    n = (kb == 0) ? 1 : ((kb > 8) ? 8 : int'(kb));
    if (n == 8) begin
      return '1;
    end
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic reply_t apply_set_request(logic [ACT_W-1:0] act,
                                               logic [KEY_W-1:0] raw_key);
    logic [KEY_W-1:0] m;
    logic [KEY_W-1:0] k;
    logic [LOW_W-1:0] lo;
    int               base;
    int               hit;
    int               free_way;
    reply_t           r;
    m        = width_mask(shadow_kb);
    k        = raw_key & m;
    lo       = k[LOW_W-1:0];
    base     = int'(lo % LOW_W'(NUM_BUCKETS)) * WAYS;
    hit      = -1;
    free_way = -1;
    r        = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (shadow_used[base + w]) begin
        if (hit < 0 && (shadow_key[base + w] & m) == k) begin
          hit = w;
        end
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    case (act)
      ACT_ADD: begin
        if (hit < 0) begin
          if (free_way < 0) begin
            r.bucket_full = 1'b1;
          end else begin
            shadow_key[base + free_way]  = k;
            shadow_used[base + free_way] = 1'b1;
            r.success = 1'b1;
          end
        end
      end
      ACT_CONTAINS: begin
        r.success = (hit >= 0);
      end
      ACT_REMOVE: begin
        if (hit >= 0) begin
          shadow_used[base + hit] = 1'b0;
          r.success = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // mostly back to back or short gaps, now and then a long one; none when quiet
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic offer_request(logic [ACT_W-1:0] act, logic [KEY_W-1:0] key, bit quiet);
    int gap;
    gap = pick_gap(quiet);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.action <= act;
    req_if.key    <= key;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic write_key_bytes(logic [KB_W-1:0] kb);
    cfg_if.valid     <= 1'b1;
    cfg_if.key_bytes <= kb;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    shadow_kb = kb;
  endtask

  task automatic drain_replies();
    req_if.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // request side: directed table, then random phases per key width
  initial begin : request_side
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int               hot [HOT_BUCKETS];
    logic [LOW_W-1:0] lo;
    logic [KEY_W-1:0] key;
    logic [ACT_W-1:0] act;
    logic [KB_W-1:0]  kb;
    reply_t           r;
    int               roll;
    bit               quiet;

    req_if.valid     <= 1'b0;
    req_if.action    <= ACT_ADD;
    req_if.key       <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.key_bytes <= KB_RESET;
    shadow_kb    = KB_RESET;
    error_count  = 0;
    rsp_hold_req = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_used[i] = 1'b0;
      shadow_key[i]  = '0;
    end

    while (!rst_ni) @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      offer_request(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].key, 1'b0);
      r = apply_set_request(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].key);
      if (DIRECTED_ROWS[i].typed) begin
        r.success     = DIRECTED_ROWS[i].success;
        r.bucket_full = DIRECTED_ROWS[i].bucket_full;
      end
      pending_replies.push_back(r);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_replies();
      kb = (p == PHASES - 1) ? KB_W'($urandom_range(0, 15)) : KB_PLAN[p];
      write_key_bytes(kb);

      // crowd a few buckets so that adds run into full buckets
      for (int i = 0; i < HOT_BUCKETS; i++) begin
        hot[i] = $urandom_range(0, NUM_BUCKETS - 1);
      end
      for (int i = 0; i < POOL_SIZE; i++) begin
        lo = $urandom;
        lo = lo - lo % LOW_W'(NUM_BUCKETS) + LOW_W'(hot[i % HOT_BUCKETS]);
        key_pool[i] = {32'($urandom), lo};
      end

      if (p == 1) begin
        rsp_hold_req = 1'b1;
        quiet = 1'b1;
      end else begin
        quiet = ($urandom_range(0, 3) == 0);
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 88) begin
          key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
          if ($urandom_range(0, 1) == 1) begin
            key = key & width_mask(shadow_kb);
          end
        end else begin
          key = {32'($urandom), 32'($urandom)};
        end
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          act = ACT_ADD;
        end else if (roll < 70) begin
          act = ACT_CONTAINS;
        end else if (roll < 95) begin
          act = ACT_REMOVE;
        end else begin
          act = ACT_UNUSED;
        end
        offer_request(act, key, quiet);
        pending_replies.push_back(apply_set_request(act, key));
      end
    end

    drain_replies();
    repeat (LATENCY + 4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // response side: random ready, with one long hold-off on request
  initial begin : response_side
    int run;
    int lo_cycles;
    rsp_if.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    rsp_if.ready <= 1'b1;
    forever begin
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
      repeat (run) @(posedge clk_i);
      if (rsp_hold_req) begin
        rsp_hold_req = 1'b0;
        lo_cycles = RSP_HOLD_CYCLES;
      end else begin
        lo_cycles = pick_gap(1'b0);
      end
      if (lo_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (lo_cycles) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_replies.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("%0t: response with no request pending: success %0b bucket_full %0b",
                   $time, rsp_if.success, rsp_if.bucket_full);
        end
      end else begin
        want = pending_replies.pop_front();
        if (rsp_if.success !== want.success) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: success mismatch: expected %0b actual %0b",
                     $time, want.success, rsp_if.success);
          end
        end
        if (rsp_if.bucket_full !== want.bucket_full) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: bucket_full mismatch: expected %0b actual %0b",
                     $time, want.bucket_full, rsp_if.bucket_full);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
